FILE: hw/rtl/omf_record_flattener_core_defines.svh
// assertion macros of the object-record flattener checker
// no dependencies; included by files that assert
`ifndef OMF_RECORD_FLATTENER_CORE_DEFINES_SVH
`define OMF_RECORD_FLATTENER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define OMFRF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("omfrf same-cycle check failed");

// next-cycle implication, off during reset
`define OMFRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("omfrf next-cycle check failed");

`endif

FILE: hw/rtl/omfrf_pkg.sv
// shared types and constants of the object-record flattener
// no dependencies; used by omfrf_parser, the top level and the checker
package omfrf_pkg;

  // record type bytes
  localparam logic [7:0] REC_THEADR   = 8'h80;
  localparam logic [7:0] REC_COMENT   = 8'h88;
  localparam logic [7:0] REC_MODEND   = 8'h8A;
  localparam logic [7:0] REC_MODEND32 = 8'h8B;
  localparam logic [7:0] REC_LNAMES   = 8'h96;
  localparam logic [7:0] REC_SEGDEF   = 8'h98;
  localparam logic [7:0] REC_SEGDEF32 = 8'h99;
  localparam logic [7:0] REC_GRPDEF   = 8'h9A;
  localparam logic [7:0] REC_LEDATA   = 8'hA0;
  localparam logic [7:0] REC_LEDATA32 = 8'hA1;
  localparam logic [7:0] REC_LIDATA   = 8'hA2;
  localparam logic [7:0] REC_LIDATA32 = 8'hA3;

  localparam logic [7:0] SEGMENT_RESET = 8'd1;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_MODEND = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ERR_ZERO_LEN  = 4'd0,
    ERR_OVERRUN   = 4'd1,
    ERR_SEGMENT   = 4'd2,
    ERR_OFFSET    = 4'd3,
    ERR_DIRECT    = 4'd4,
    ERR_NESTED    = 4'd5,
    ERR_BLOCKSIZE = 4'd6,
    ERR_TOO_LONG  = 4'd7,
    ERR_TYPE      = 4'd8
  } err_t;

  // one result word as the parser produces it
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    err_t       err;
    logic       pending;
  } res_t;

endpackage

FILE: hw/rtl/omfrf_parser.sv
// record parser state machine: takes one word per step and forms its result
// depends on omfrf_pkg
module omfrf_parser import omfrf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       req_type,
  input  logic [7:0] in_byte,
  input  logic [7:0] expected_segment,
  output res_t       res
);

  typedef enum logic [3:0] {
    PH_TYPE, PH_LEN_LO, PH_LEN_HI, PH_SKIP, PH_SEG, PH_OFS, PH_DATA, PH_RC0,
    PH_BC0, PH_RC1, PH_BC1, PH_BSIZE, PH_RVAL, PH_EXPAND, PH_CHECKSUM, PH_HALT
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  record_kind, record_kind_next;
  logic [15:0] record_left, record_left_next;
  logic [31:0] field_accum, field_accum_next;
  logic [1:0]  field_bytes_seen, field_bytes_seen_next;
  logic [15:0] next_offset, next_offset_next;
  logic        offset_known, offset_known_next;
  logic [31:0] outer_repeat, outer_repeat_next;
  logic [31:0] inner_repeat, inner_repeat_next;
  logic [31:0] outer_left, outer_left_next;
  logic [31:0] inner_left, inner_left_next;
  logic [15:0] subblocks_left, subblocks_left_next;
  logic [7:0]  repeat_value, repeat_value_next;
  logic [15:0] block_step, block_step_next;

  logic [31:0] acc_ins;
  logic [31:0] block_prod;
  logic [15:0] rl_dec, sub_dec, len, ofs_base;
  logic [31:0] outer_dec, inner_dec;
  logic        wide_ofs, wide_cnt, ofs_done, cnt_done, short_done;
  logic        err_hit;
  err_t        err_val;

  // only the low 16 bits of outer*inner move the offset
  assign block_prod = outer_repeat[15:0] * inner_repeat[15:0];

  assign acc_ins    = field_accum | ({24'd0, in_byte} << {field_bytes_seen, 3'd0});
  assign wide_ofs   = (record_kind == REC_LEDATA32) || (record_kind == REC_LIDATA32);
  assign wide_cnt   = (record_kind == REC_LIDATA32);
  assign short_done = (field_bytes_seen != 2'd0);
  assign ofs_done   = wide_ofs ? (field_bytes_seen == 2'd3) : short_done;
  assign cnt_done   = wide_cnt ? (field_bytes_seen == 2'd3) : short_done;
  assign rl_dec     = record_left - 16'd1;
  assign sub_dec    = subblocks_left - 16'd1;
  assign outer_dec  = outer_left - 32'd1;
  assign inner_dec  = inner_left - 32'd1;
  assign len        = {in_byte, field_accum[7:0]};
  assign ofs_base   = offset_known ? next_offset : acc_ins[15:0];

  always_comb begin
    phase_next            = phase;
    record_kind_next      = record_kind;
    record_left_next      = record_left;
    field_accum_next      = field_accum;
    field_bytes_seen_next = field_bytes_seen;
    next_offset_next      = next_offset;
    offset_known_next     = offset_known;
    outer_repeat_next     = outer_repeat;
    inner_repeat_next     = inner_repeat;
    outer_left_next       = outer_left;
    inner_left_next       = inner_left;
    subblocks_left_next   = subblocks_left;
    repeat_value_next     = repeat_value;
    block_step_next       = block_step;
    res.kind              = KIND_NONE;
    res.data              = 8'd0;
    res.err               = ERR_ZERO_LEN;
    res.pending           = 1'b0;
    err_hit               = 1'b0;
    err_val               = ERR_ZERO_LEN;

    if (step) begin
      unique case (phase)
        PH_HALT: begin
        end
        PH_EXPAND: begin
          if (req_type) begin
            res.kind        = KIND_DATA;
            res.data        = repeat_value;
            inner_left_next = inner_dec;
            if (inner_dec == 32'd0) begin
              outer_left_next = outer_dec;
              if (outer_dec == 32'd0) begin
                subblocks_left_next = sub_dec;
                phase_next = (sub_dec != 16'd0) ? PH_RC1 : PH_CHECKSUM;
              end else begin
                inner_left_next = inner_repeat;
              end
            end
          end
        end
        PH_TYPE: begin
          if (!req_type) begin
            record_kind_next = in_byte;
            phase_next       = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          if (!req_type) begin
            field_accum_next = {24'd0, in_byte};
            phase_next       = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          if (!req_type) begin
            field_accum_next      = 32'd0;
            field_bytes_seen_next = 2'd0;
            record_left_next      = len - 16'd1;
            if (len == 16'd0) begin
              err_hit = 1'b1;
              err_val = ERR_ZERO_LEN;
            end else if (record_kind == REC_MODEND || record_kind == REC_MODEND32) begin
              res.kind   = KIND_MODEND;
              phase_next = PH_HALT;
            end else if (record_kind inside {REC_THEADR, REC_COMENT, REC_LNAMES,
                                             REC_SEGDEF, REC_SEGDEF32, REC_GRPDEF}) begin
              phase_next = (len != 16'd1) ? PH_SKIP : PH_CHECKSUM;
            end else if (record_kind inside {REC_LEDATA, REC_LEDATA32,
                                             REC_LIDATA, REC_LIDATA32}) begin
              phase_next = PH_SEG;
            end else begin
              err_hit = 1'b1;
              err_val = ERR_TYPE;
            end
          end
        end
        PH_CHECKSUM: begin
          if (!req_type) begin
            if (record_left != 16'd0) begin
              err_hit = 1'b1;
              err_val = ERR_TOO_LONG;
            end else begin
              phase_next = PH_TYPE;
            end
          end
        end
        PH_SKIP, PH_SEG, PH_OFS, PH_DATA, PH_RC0, PH_BC0, PH_RC1, PH_BC1, PH_BSIZE,
        PH_RVAL: begin
          if (!req_type) begin
            if (record_left == 16'd0) begin
              err_hit = 1'b1;
              err_val = ERR_OVERRUN;
            end else begin
              record_left_next = rl_dec;
              unique case (phase)
                PH_SKIP: begin
                  if (rl_dec == 16'd0) phase_next = PH_CHECKSUM;
                end
                PH_SEG: begin
                  if (in_byte != expected_segment) begin
                    err_hit = 1'b1;
                    err_val = ERR_SEGMENT;
                  end else begin
                    field_accum_next      = 32'd0;
                    field_bytes_seen_next = 2'd0;
                    phase_next            = PH_OFS;
                  end
                end
                PH_OFS: begin
                  if (!ofs_done) begin
                    field_accum_next      = acc_ins;
                    field_bytes_seen_next = field_bytes_seen + 2'd1;
                  end else begin
                    field_accum_next      = 32'd0;
                    field_bytes_seen_next = 2'd0;
                    // high word of a wide offset is ignored
                    if (offset_known && acc_ins[15:0] != next_offset) begin
                      err_hit = 1'b1;
                      err_val = ERR_OFFSET;
                    end else begin
                      offset_known_next = 1'b1;
                      if (record_kind == REC_LEDATA || record_kind == REC_LEDATA32) begin
                        next_offset_next = ofs_base + rl_dec;
                        phase_next = (rl_dec != 16'd0) ? PH_DATA : PH_CHECKSUM;
                      end else begin
                        next_offset_next = ofs_base;
                        phase_next       = PH_RC0;
                      end
                    end
                  end
                end
                PH_DATA: begin
                  res.kind = KIND_DATA;
                  res.data = in_byte;
                  if (rl_dec == 16'd0) phase_next = PH_CHECKSUM;
                end
                PH_RC0: begin
                  if (!cnt_done) begin
                    field_accum_next      = acc_ins;
                    field_bytes_seen_next = field_bytes_seen + 2'd1;
                  end else begin
                    field_accum_next      = 32'd0;
                    field_bytes_seen_next = 2'd0;
                    outer_repeat_next     = acc_ins;
                    phase_next            = PH_BC0;
                  end
                end
                PH_BC0: begin
                  if (!short_done) begin
                    field_accum_next      = acc_ins;
                    field_bytes_seen_next = field_bytes_seen + 2'd1;
                  end else begin
                    field_accum_next      = 32'd0;
                    field_bytes_seen_next = 2'd0;
                    if (acc_ins[15:0] == 16'd0) begin
                      err_hit = 1'b1;
                      err_val = ERR_DIRECT;
                    end else begin
                      subblocks_left_next = acc_ins[15:0];
                      phase_next          = PH_RC1;
                    end
                  end
                end
                PH_RC1: begin
                  if (!cnt_done) begin
                    field_accum_next      = acc_ins;
                    field_bytes_seen_next = field_bytes_seen + 2'd1;
                  end else begin
                    field_accum_next      = 32'd0;
                    field_bytes_seen_next = 2'd0;
                    inner_repeat_next     = acc_ins;
                    phase_next            = PH_BC1;
                  end
                end
                PH_BC1: begin
                  if (!short_done) begin
                    field_accum_next      = acc_ins;
                    field_bytes_seen_next = field_bytes_seen + 2'd1;
                  end else begin
                    field_accum_next      = 32'd0;
                    field_bytes_seen_next = 2'd0;
                    // offset step of this subblock, used once its value arrives
                    block_step_next       = block_prod[15:0];
                    if (acc_ins[15:0] != 16'd0) begin
                      err_hit = 1'b1;
                      err_val = ERR_NESTED;
                    end else begin
                      phase_next = PH_BSIZE;
                    end
                  end
                end
                PH_BSIZE: begin
                  field_accum_next = {24'd0, in_byte};
                  phase_next       = PH_RVAL;
                end
                default: begin
                  repeat_value_next = in_byte;
                  if (field_accum != 32'd1) begin
                    err_hit = 1'b1;
                    err_val = ERR_BLOCKSIZE;
                  end else begin
                    field_accum_next = 32'd0;
                    next_offset_next = next_offset + block_step;
                    outer_left_next  = outer_repeat;
                    inner_left_next  = inner_repeat;
                    if (outer_repeat != 32'd0 && inner_repeat != 32'd0) begin
                      phase_next = PH_EXPAND;
                    end else begin
                      subblocks_left_next = sub_dec;
                      phase_next = (sub_dec != 16'd0) ? PH_RC1 : PH_CHECKSUM;
                    end
                  end
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (err_hit) begin
      phase_next = PH_HALT;
      res.kind   = KIND_ERROR;
      res.data   = 8'd0;
      res.err    = err_val;
    end
    res.pending = (phase_next == PH_EXPAND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_TYPE;
      record_kind      <= 8'd0;
      record_left      <= 16'd0;
      field_accum      <= 32'd0;
      field_bytes_seen <= 2'd0;
      next_offset      <= 16'd0;
      offset_known     <= 1'b0;
      outer_repeat     <= 32'd0;
      inner_repeat     <= 32'd0;
      outer_left       <= 32'd0;
      inner_left       <= 32'd0;
      subblocks_left   <= 16'd0;
      repeat_value     <= 8'd0;
      block_step       <= 16'd0;
    end else begin
      phase            <= phase_next;
      record_kind      <= record_kind_next;
      record_left      <= record_left_next;
      field_accum      <= field_accum_next;
      field_bytes_seen <= field_bytes_seen_next;
      next_offset      <= next_offset_next;
      offset_known     <= offset_known_next;
      outer_repeat     <= outer_repeat_next;
      inner_repeat     <= inner_repeat_next;
      outer_left       <= outer_left_next;
      inner_left       <= inner_left_next;
      subblocks_left   <= subblocks_left_next;
      repeat_value     <= repeat_value_next;
      block_step       <= block_step_next;
    end
  end

endmodule

FILE: hw/rtl/omf_record_flattener_core.sv
// top level of the object-record flattener: stream ports, segment register, result register
// depends on omfrf_pkg and omfrf_parser
//
// Parses an object-file byte stream one word per clock while the output side is ready: every
// accepted input word (a stream byte, or a drain request that pulls the next repeated byte
// of an iterated-data record) gives exactly one output word in the next cycle, held in an
// output register. The input side stays ready while that register is empty or being
// taken, so with the output side ready the block sustains one word per cycle in both
// directions; the record state machine updates all its counters in the cycle of the
// accept. Iterated records need one drain word per expanded byte; watch
// expand_pending. After module end or any error the block answers every word with
// kind "nothing" until reset. The expected segment register (reset 1) is always
// ready and should be written only while the block is idle.
module omf_record_flattener_core import omfrf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic [0:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_byte[7:0], error_code[11:8], expand_pending[12]
  output logic [1:0]  m_axis_tuser,   // out_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // expected_segment
);

  logic       accept;
  logic [7:0] expected_segment;
  res_t       res;
  res_t       out_word;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  omfrf_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .step             (accept),
    .req_type         (s_axis_tuser[0]),
    .in_byte          (s_axis_tdata),
    .expected_segment (expected_segment),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_segment <= SEGMENT_RESET;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid) expected_segment <= cfg_data;
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_word <= res;
  end

  assign m_axis_tuser = out_word.kind;
  assign m_axis_tdata = {3'd0, out_word.pending, out_word.err, out_word.data};

endmodule

FILE: hw/rtl/omfrf_checker.sv
// port-level checks of the object-record flattener and their bind to the top level
// depends on omfrf_pkg and omf_record_flattener_core_defines.svh
`include "omf_record_flattener_core_defines.svh"

module omfrf_checker import omfrf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled word keeps its contents
  `OMFRF_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // every accepted word has its result on the output next cycle
  `OMFRF_ASSERT_NEXT(a_result_follows, clk, rst, s_axis_tvalid && s_axis_tready, m_axis_tvalid)

  // error code only on error words, data byte only on data words
  `OMFRF_ASSERT_IMPL(a_err_only, clk, rst, m_axis_tvalid && m_axis_tuser != KIND_ERROR, m_axis_tdata[11:8] == 4'd0)
  `OMFRF_ASSERT_IMPL(a_byte_only, clk, rst, m_axis_tvalid && m_axis_tuser != KIND_DATA, m_axis_tdata[7:0] == 8'd0)

  // stopping words never leave expansion pending
  `OMFRF_ASSERT_IMPL(a_stop_clear, clk, rst, m_axis_tvalid && (m_axis_tuser == KIND_ERROR || m_axis_tuser == KIND_MODEND), !m_axis_tdata[12])

endmodule

bind omf_record_flattener_core omfrf_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
